@@ rtl/xcfc_pkg.sv @@
package xcfc_pkg;

   localparam logic [7:0] CHAR_NL = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;

   localparam logic [7:0] START_CHAR_RESET = 8'd65;
   localparam logic [7:0] DELIM_CHAR_RESET = 8'd42;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MISMATCH  = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   // register indexes on the configuration port
   localparam logic REG_START_CHAR = 1'b0;
   localparam logic REG_DELIM_CHAR = 1'b1;

   localparam int PADDR_W = 3;

   typedef struct packed {
      logic [7:0] start_char;
      logic [7:0] delim_char;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      logic [7:0] d;
      h.ok    = 1'b0;
      h.value = 4'd0;
      d       = 8'd0;
      if (b >= 8'd48 && b <= 8'd57) begin
         d = b - 8'd48;
         h.ok = 1'b1;
      end else if (b >= 8'd65 && b <= 8'd70) begin
         d = b - 8'd55;
         h.ok = 1'b1;
      end else if (b >= 8'd97 && b <= 8'd102) begin
         d = b - 8'd87;
         h.ok = 1'b1;
      end
      h.value = d[3:0];
      return h;
   endfunction

endpackage

@@ rtl/xcfc_csr.sv @@
module xcfc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [xcfc_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output xcfc_pkg::cfg_type            cfg
);
   import xcfc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_START_CHAR: cfg_in.start_char = pwdata[7:0];
            REG_DELIM_CHAR: cfg_in.delim_char = pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_char <= START_CHAR_RESET;
         cfg_ff.delim_char <= DELIM_CHAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_START_CHAR: prdata = {24'd0, cfg_ff.start_char};
         REG_DELIM_CHAR: prdata = {24'd0, cfg_ff.delim_char};
         default:        prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/xcfc_in_stage.sv @@
module xcfc_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               take,
   output xcfc_pkg::item_type item
);
   import xcfc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // refill in the same cycle the held request moves on
   assign req_ready = !valid_ff || take;
   assign valid_in  = (valid_ff && !take) || (req_valid && req_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

@@ rtl/xcfc_frame.sv @@
module xcfc_frame (
   input  logic               clock,
   input  logic               reset,
   input  xcfc_pkg::cfg_type  cfg,
   input  xcfc_pkg::item_type item,
   output logic               take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_computed_xor,
   output logic [7:0]         rsp_received_sum
);
   import xcfc_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PAYLOAD,
      PH_DIGITS
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] sent_ff, sent_in;
   logic [1:0] count_ff, count_in;
   logic       bad_ff, bad_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic [7:0] comp_ff;
   logic [7:0] recv_ff;
   logic       emit;
   hex_type    hex;
   logic [7:0] b;

   assign b    = item.rx_byte;
   assign hex  = hex_decode(b);
   assign take = item.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      phase_in  = phase_ff;
      xor_in    = xor_ff;
      sent_in   = sent_ff;
      count_in  = count_ff;
      bad_in    = bad_ff;
      emit      = 1'b0;
      status_in = ST_MALFORMED;
      if (count_ff != 2'd0 && !bad_ff && phase_ff == PH_DIGITS) begin
         status_in = (sent_ff == xor_ff) ? ST_OK : ST_MISMATCH;
      end
      if (take) begin
         unique case (phase_ff)
            PH_PAYLOAD, PH_DIGITS: begin
               if (b == CHAR_NL) begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
                  xor_in   = 8'd0;
                  sent_in  = 8'd0;
                  count_in = 2'd0;
                  bad_in   = 1'b0;
               end else if (b == CHAR_CR) begin
                  phase_in = phase_ff;
               end else if (phase_ff == PH_PAYLOAD) begin
                  if (b == cfg.delim_char) begin
                     phase_in = PH_DIGITS;
                  end else begin
                     xor_in = xor_ff ^ b;
                  end
               end else if (!hex.ok || count_ff == 2'd2) begin
                  bad_in = 1'b1;
               end else begin
                  sent_in  = {sent_ff[3:0], hex.value};
                  count_in = count_ff + 2'd1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (b == cfg.start_char) begin
                  phase_in = PH_PAYLOAD;
                  xor_in   = 8'd0;
                  sent_in  = 8'd0;
                  count_in = 2'd0;
                  bad_in   = 1'b0;
               end
            end
         endcase
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         xor_ff       <= 8'd0;
         sent_ff      <= 8'd0;
         count_ff     <= 2'd0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         xor_ff       <= xor_in;
         sent_ff      <= sent_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            status_ff <= status_in;
            comp_ff   <= xor_ff;
            recv_ff   <= sent_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_computed_xor = comp_ff;
   assign rsp_received_sum = recv_ff;

endmodule

@@ rtl/xcfc_top.sv @@
// Path: a request that ends a frame is held in the input register, then its response is
// set in the response register.
// Throughput: one request per cycle; the frame state is updated for each taken request. Input
// stalls only while a finished response waits on rsp_ready and the input register is full.
// Reset: synchronous, active high; clears frame state, both valid flags and restores
// start_char to 'A' and delim_char to '*'.
module xor_checksum_frame_checker_top (
   input  logic                         clock,
   input  logic                         reset,
   // request channel: one received character per request
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_rx_byte,
   // response channel: one per completed frame
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [7:0]                   rsp_computed_xor,
   output logic [7:0]                   rsp_received_sum,
   // configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [xcfc_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import xcfc_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     take;

   // hold start and delimiter characters
   xcfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // register the incoming request; it can refill while a response waits
   xcfc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .item        (item)
   );

   // advance the frame parser and register the response
   xcfc_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .item             (item),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_xor (rsp_computed_xor),
      .rsp_received_sum (rsp_received_sum)
   );

   // a match report must carry equal sums
   a_ok_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |-> (rsp_computed_xor == rsp_received_sum))
      else $error("ok status with differing sums");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_MISMATCH ||
                     rsp_status == ST_MALFORMED))
      else $error("undefined status code");

   // an empty input register always accepts
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !item.valid |-> req_ready)
      else $error("input register empty but request refused");

   // drop every pending response on reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !item.valid))
      else $error("valid flag survived reset");

endmodule

@@ verif/xor_checksum_frame_checker_top_tb.sv @@
`timescale 1ns / 100ps

module xor_checksum_frame_checker_top_tb;
   import xcfc_pkg::*;

   localparam int unsigned QUIET_CYCLES = 4;     // two-stage pipe plus margin
   localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int unsigned STALL_LIMIT  = 4000;  // cycles without any transfer

   // frame state of the checker as the scoreboard tracks it
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DIGITS  = 2'd2
   } frame_phase_type;

   // shapes of frames the generator can build
   typedef enum int {
      FK_GOOD,
      FK_WRONG,
      FK_ONE_DIGIT,
      FK_NO_DELIM,
      FK_NO_DIGITS,
      FK_BAD_DIGIT,
      FK_EXTRA_DIGIT,
      FK_NOISE
   } frame_kind_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] computed_xor;
      logic [7:0] received_sum;
   } frame_report_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_computed_xor;
   logic [7:0]  rsp_received_sum;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // scoreboard copy of the checker: registers and frame state
   cfg_type         sb_cfg;
   frame_phase_type sb_phase;
   logic [7:0]      sb_xor;
   logic [7:0]      sb_sent;
   logic [1:0]      sb_digits;
   logic            sb_bad;

   frame_report_type pending_reports[$];
   frame_report_type got_report;
   frame_report_type want_report;

   int unsigned fail_count     = 0;
   int unsigned requests_sent  = 0;
   int unsigned reports_seen   = 0;
   int unsigned ok_seen        = 0;
   int unsigned mismatch_seen  = 0;
   int unsigned malformed_seen = 0;
   int unsigned settings_run   = 1;

   // traffic shaping knobs, set by the test sequence
   bit          send_idle_on = 1'b1;
   bit          rsp_idle_on  = 1'b1;
   bit          hold_off_go  = 1'b0;
   int unsigned ready_gap    = 0;
   int unsigned held_cycles  = 0;
   int unsigned stall_cycles = 0;

   xor_checksum_frame_checker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_xor (rsp_computed_xor),
      .rsp_received_sum (rsp_received_sum),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Scoreboard
   // ------------------------------------------------------------------

   // Decode one hex character: bit 4 flags a non-hex byte.
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      if (b inside {[8'h30:8'h39]})
         return {1'b0, b[3:0]};
      if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
         return {1'b0, b[3:0] + 4'd9};
      return 5'h10;
   endfunction

   function automatic void clear_frame();
      sb_xor    = 8'd0;
      sb_sent   = 8'd0;
      sb_digits = 2'd0;
      sb_bad    = 1'b0;
   endfunction

   // Advance the frame state by one accepted request; queue a report on newline.
   function automatic void track_byte(input logic [7:0] b);
      frame_report_type rep;
      logic [4:0]       nib;
      if (sb_phase == PH_IDLE) begin
         // outside a frame only the start character matters
         if (b == sb_cfg.start_char) begin
            clear_frame();
            sb_phase = PH_PAYLOAD;
         end
      end else if (b == CHAR_NL) begin
         // newline closes the frame whatever the configured characters are
         if (sb_phase == PH_PAYLOAD || sb_bad || sb_digits == 2'd0)
            rep.status = ST_MALFORMED;
         else if (sb_sent == sb_xor)
            rep.status = ST_OK;
         else
            rep.status = ST_MISMATCH;
         rep.computed_xor = sb_xor;
         rep.received_sum = sb_sent;
         pending_reports.push_back(rep);
         clear_frame();
         sb_phase = PH_IDLE;
      end else if (b == CHAR_CR) begin
         // carriage return is dropped inside a frame
      end else if (sb_phase == PH_PAYLOAD) begin
         if (b == sb_cfg.delim_char)
            sb_phase = PH_DIGITS;
         else
            sb_xor = sb_xor ^ b;
      end else begin
         nib = hex_nibble(b);
         if (nib[4] || sb_digits == 2'd2) begin
            sb_bad = 1'b1;
         end else begin
            sb_sent   = {sb_sent[3:0], nib[3:0]};
            sb_digits = sb_digits + 2'd1;
         end
      end
   endfunction

   // Track every accepted request.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         track_byte(req_rx_byte);
   end

   // Check every accepted response against the oldest pending report.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_report = '{rsp_status, rsp_computed_xor, rsp_received_sum};
         if (pending_reports.size() == 0) begin
            $error("unexpected response: status %0d computed_xor %02h received_sum %02h",
                   rsp_status, rsp_computed_xor, rsp_received_sum);
            fail_count++;
         end else begin
            want_report = pending_reports.pop_front();
            reports_seen++;
            case (want_report.status)
               ST_OK:       ok_seen++;
               ST_MISMATCH: mismatch_seen++;
               default:     malformed_seen++;
            endcase
            if (got_report.status !== want_report.status) begin
               $error("status: expected %0d, got %0d", want_report.status, got_report.status);
               fail_count++;
            end
            if (got_report.computed_xor !== want_report.computed_xor) begin
               $error("computed_xor: expected %02h, got %02h",
                      want_report.computed_xor, got_report.computed_xor);
               fail_count++;
            end
            if (got_report.received_sum !== want_report.received_sum) begin
               $error("received_sum: expected %02h, got %02h",
                      want_report.received_sum, got_report.received_sum);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response side: random ready bursts, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            // hold ready low for the whole stretch, then release
            if (held_cycles == HOLD_CYCLES) begin
               hold_off_go = 1'b0;
               held_cycles = 0;
               rsp_ready <= 1'b1;
            end else begin
               held_cycles++;
               rsp_ready <= 1'b0;
            end
         end else if (ready_gap != 0) begin
            ready_gap--;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            // start a stall of random length
            ready_gap = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if no request, response or register access moves
   // ------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT)
            break;
      end
      $display("watchdog: no transfer for %0d cycles, %0d reports still pending",
               STALL_LIMIT, pending_reports.size());
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one request and hold it until accepted; optionally idle first.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (send_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Drop valid and wait until every pending report is back and the pipe is empty.
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_START_CHAR)
         sb_cfg.start_char = val;
      else
         sb_cfg.delim_char = val;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Read a register back and compare with the scoreboard copy.
   task automatic csr_check(input logic idx);
      logic [7:0] want;
      want = (idx == REG_START_CHAR) ? sb_cfg.start_char : sb_cfg.delim_char;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== want) begin
         $error("%s: expected %02h, got %02h",
                (idx == REG_START_CHAR) ? "start_char" : "delim_char", want, prdata[7:0]);
         fail_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_setting(input cfg_type setting);
      wait_quiet();
      csr_write(REG_START_CHAR, setting.start_char);
      csr_write(REG_DELIM_CHAR, setting.delim_char);
      csr_check(REG_START_CHAR);
      csr_check(REG_DELIM_CHAR);
   endtask

   // ------------------------------------------------------------------
   // Frame generator
   // ------------------------------------------------------------------

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10)
         return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h57 : 8'h37) + n;
   endfunction

   // Payload byte that neither ends the frame nor hits the delimiter.
   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CHAR_NL || b == CHAR_CR || b == sb_cfg.delim_char);
      return b;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      logic [4:0] nib;
      do begin
         b   = 8'($urandom_range(0, 255));
         nib = hex_nibble(b);
      end while (b == CHAR_NL || b == CHAR_CR || !nib[4]);
      return b;
   endfunction

   // Build one frame of the given kind with random content and send it.
   task automatic send_frame(input frame_kind_type kind, input int unsigned max_len);
      logic [7:0]  frame_bytes[$];
      logic [7:0]  sum;
      logic [7:0]  sent;
      int unsigned len;
      sum = 8'd0;
      if (kind == FK_NOISE) begin
         // stray bytes between frames; may open a frame of their own
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         return;
      end
      frame_bytes.push_back(sb_cfg.start_char);
      len = $urandom_range(0, max_len);
      repeat (len) begin
         if ($urandom_range(0, 9) == 0) begin
            frame_bytes.push_back(CHAR_CR);
         end else begin
            frame_bytes.push_back(payload_byte());
            sum = sum ^ frame_bytes[$];
         end
      end
      if (kind != FK_NO_DELIM)
         frame_bytes.push_back(sb_cfg.delim_char);
      sent = (kind == FK_WRONG) ? sum ^ 8'($urandom_range(1, 255)) : sum;
      case (kind)
         FK_GOOD, FK_WRONG: begin
            frame_bytes.push_back(hex_char(sent[7:4]));
            frame_bytes.push_back(hex_char(sent[3:0]));
         end
         FK_ONE_DIGIT: frame_bytes.push_back(hex_char(sent[3:0]));
         FK_BAD_DIGIT: begin
            if ($urandom_range(0, 1))
               frame_bytes.push_back(hex_char(sent[7:4]));
            frame_bytes.push_back($urandom_range(0, 3) == 0 ? sb_cfg.delim_char
                                                             : non_hex_byte());
            frame_bytes.push_back(hex_char(sent[3:0]));
         end
         FK_EXTRA_DIGIT: begin
            frame_bytes.push_back(hex_char(sent[7:4]));
            frame_bytes.push_back(hex_char(sent[3:0]));
            frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
         end
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
         frame_bytes.push_back(CHAR_CR);
      frame_bytes.push_back(CHAR_NL);
      foreach (frame_bytes[i])
         send_byte(frame_bytes[i]);
   endtask

   // Mostly well-formed frames, the rest broken frames and noise.
   task automatic send_random_frames(input int unsigned count);
      int unsigned    stop_at;
      int unsigned    pick;
      frame_kind_type kind;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)      kind = FK_GOOD;
         else if (pick < 70) kind = FK_WRONG;
         else if (pick < 76) kind = FK_ONE_DIGIT;
         else if (pick < 81) kind = FK_NO_DELIM;
         else if (pick < 85) kind = FK_NO_DIGITS;
         else if (pick < 90) kind = FK_BAD_DIGIT;
         else if (pick < 95) kind = FK_EXTRA_DIGIT;
         else                kind = FK_NOISE;
         // keep most frames short, allow an occasional long payload
         send_frame(kind, ($urandom_range(0, 19) == 0) ? 24 : 8);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values must read back before anything is written.
   task automatic test_reset_values();
      csr_check(REG_START_CHAR);
      csr_check(REG_DELIM_CHAR);
   endtask

   // Hand-built frames under the reset setting.
   task automatic test_directed();
      logic [7:0] seq[$];
      seq = {
         8'h00, 8'hFF, CHAR_NL,                          // idle bytes, newline ignored
         "A", 8'h00, 8'hFF, "A", CHAR_CR, "*", "b", "E",  // start inside frame, CR skipped
         CHAR_CR, CHAR_NL,                               // match, mixed-case digits
         "A", "Z", "*", "1", CHAR_NL,                    // single digit, mismatch
         "A", "q", CHAR_NL,                              // delimiter missing
         "A", "*", CHAR_NL,                              // delimiter with no digits
         "A", "*", "g", "*", CHAR_NL,                    // bad digit, second delimiter
         "A", "*", "0", "0", "0", CHAR_NL                // third digit
      };
      foreach (seq[i])
         send_byte(seq[i]);
      wait_quiet();
   endtask

   // Sweep register settings, extremes included, with random frames in each.
   task automatic test_setting_sweep();
      cfg_type settings[$];
      settings = {
         cfg_type'({8'h00, 8'hFF}),
         cfg_type'({8'hFF, 8'h00}),
         cfg_type'({8'h24, 8'h2A}),       // '$' and '*'
         cfg_type'({CHAR_NL, CHAR_NL}),   // newline starts a frame and wins over the delimiter
         cfg_type'({8'h41, 8'h37}),       // delimiter that is also a hex digit
         cfg_type'({START_CHAR_RESET, DELIM_CHAR_RESET})
      };
      foreach (settings[i]) begin
         apply_setting(settings[i]);
         settings_run++;
         send_random_frames(110);
      end
   endtask

   // Hold the receiver off while frames keep coming, then drain completely.
   task automatic test_backpressure();
      hold_off_go = 1'b1;
      repeat (40) send_frame(FK_GOOD, 2);
      // pause the sender until every report is back
      wait_quiet();
      send_random_frames(60);
      wait_quiet();
   endtask

   // Close with back-to-back traffic and no idling on either side.
   task automatic test_steady_stream();
      send_idle_on = 1'b0;
      rsp_idle_on  = 1'b0;
      send_random_frames(150);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'd0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = 32'd0;
      sb_cfg      = '{START_CHAR_RESET, DELIM_CHAR_RESET};
      sb_phase    = PH_IDLE;
      clear_frame();

      // hold reset, then release it on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed();
      test_setting_sweep();
      test_backpressure();
      test_steady_stream();

      // drain: every report back, then let the pipe settle
      wait_quiet();

      $display("run covered %0d requests and %0d frame reports over %0d register settings",
               requests_sent, reports_seen, settings_run);
      $display("reports: %0d match, %0d mismatch, %0d malformed; %0d check failures",
               ok_seen, mismatch_seen, malformed_seen, fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
